// ===== hw/rtl/lbb_pkg.sv =====
// Shared types, constants and the breathe duty table for the LED blink/breathe controller.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package lbb_pkg;

   localparam int TIME_W = 32;
   localparam int DUTY_W = 10;
   localparam int MODE_W = 3;

   localparam logic [MODE_W-1:0] MODE_OFF     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ON      = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SLOW    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_FAST    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_BREATHE = 3'd4;

   localparam logic CSR_LED_MODE   = 1'b0;
   localparam logic CSR_ACTIVE_LOW = 1'b1;

   localparam int SLOW_HALF_PERIOD_MS = 500;
   localparam int FAST_HALF_PERIOD_MS = 150;
   localparam int BREATHE_PERIOD_MS   = 2000;
   localparam int PWM_MAX             = 1023;

   // Remainder by the breathe period via a reciprocal multiply.
   localparam int RECIP_SHIFT = 40;
   localparam longint unsigned BREATHE_RECIP = (64'd1 << RECIP_SHIFT) / BREATHE_PERIOD_MS;
   localparam int RECIP_W  = $clog2(BREATHE_RECIP + 1);
   localparam int PROD_W   = TIME_W + RECIP_W;
   localparam int QUOT_W   = PROD_W - RECIP_SHIFT;
   localparam int PERIOD_W = $clog2(BREATHE_PERIOD_MS + 1);

   // The raised-cosine curve is symmetric, so only the first half period is stored.
   localparam int BREATHE_HALF = BREATHE_PERIOD_MS / 2;
   localparam int PHASE_W      = $clog2(BREATHE_HALF + 1);

   localparam longint unsigned ONE_Q30 = 64'd1 << 30;
   localparam longint unsigned PI_Q30  = 64'd3373259426;

   typedef logic [BREATHE_HALF:0][DUTY_W-1:0] duty_table_type;

   // Evaluated at elaboration: sin by a truncated Taylor series in Q30, squared, scaled.
   function automatic duty_table_type build_duty_table();
      duty_table_type   tbl;
      longint unsigned  x;
      longint unsigned  term;
      longint unsigned  s;
      longint unsigned  q;
      longint unsigned  d;
      longint           sum;
      for (int j = 0; j <= BREATHE_HALF; j++) begin
         if (2 * j == BREATHE_PERIOD_MS) begin
            s = ONE_Q30;
         end else begin
            x    = (PI_Q30 * longint'(j)) / BREATHE_PERIOD_MS;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 7; n++) begin
               term = (((term * x) >> 30) * x) >> 30;
               // Each step divides by (2n)(2n+1) to reach the next odd power's factorial.
               case (n)
                  1:       term = term / 64'd6;
                  2:       term = term / 64'd20;
                  3:       term = term / 64'd42;
                  4:       term = term / 64'd72;
                  5:       term = term / 64'd110;
                  6:       term = term / 64'd156;
                  default: term = term / 64'd210;
               endcase
               if ((n % 2) == 1) begin
                  sum = sum - longint'(term);
               end else begin
                  sum = sum + longint'(term);
               end
            end
            if (sum < 0) begin
               sum = 0;
            end
            s = longint'(sum);
            if (s > ONE_Q30) begin
               s = ONE_Q30;
            end
         end
         q = (s * s) >> 30;
         d = (longint'(PWM_MAX) * q) >> 30;
         if (d > longint'(PWM_MAX)) begin
            d = longint'(PWM_MAX);
         end
         tbl[j] = d[DUTY_W-1:0];
      end
      return tbl;
   endfunction

   localparam duty_table_type DUTY_TABLE = build_duty_table();

   typedef struct packed {
      logic wrote;
      logic is_pwm;
      logic pin_high;
      logic active_low;
   } ctrl_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } stage_en_type;

endpackage

// ===== hw/rtl/lbb_ctrl.sv =====
// Mode and polarity registers plus the blink state machine, evaluated per accepted request.
// Depends on lbb_pkg.
`timescale 1ns / 1ps

module lbb_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [lbb_pkg::MODE_W-1:0]    csr_wdata,
   input  logic                          accept,
   input  logic [lbb_pkg::TIME_W-1:0]    now_ms,
   output lbb_pkg::ctrl_type             ctrl
);

   localparam logic [lbb_pkg::TIME_W-1:0] SLOW_HALF = 32'(lbb_pkg::SLOW_HALF_PERIOD_MS);
   localparam logic [lbb_pkg::TIME_W-1:0] FAST_HALF = 32'(lbb_pkg::FAST_HALF_PERIOD_MS);

   logic [lbb_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic                       active_low_ff, active_low_in;
   logic [lbb_pkg::TIME_W-1:0] last_toggle_ff, last_toggle_in;
   logic                       phase_ff, phase_in;
   logic                       changed_ff, changed_in;

   logic [lbb_pkg::TIME_W-1:0] ref_time;
   logic [lbb_pkg::TIME_W-1:0] elapsed;

   always_comb begin
      mode_in        = mode_ff;
      active_low_in  = active_low_ff;
      last_toggle_in = last_toggle_ff;
      phase_in       = phase_ff;
      changed_in     = changed_ff;
      ctrl           = '0;
      ctrl.active_low = active_low_ff;

      // The first tick after a mode change takes its own time as the reference.
      ref_time = changed_ff ? now_ms : last_toggle_ff;
      elapsed  = now_ms - ref_time;

      if (csr_we) begin
         unique case (csr_index)
            lbb_pkg::CSR_LED_MODE: begin
               if (csr_wdata != mode_ff) begin
                  mode_in    = csr_wdata;
                  phase_in   = 1'b0;
                  changed_in = 1'b1;
               end
            end
            lbb_pkg::CSR_ACTIVE_LOW: begin
               active_low_in = csr_wdata[0];
            end
            default: begin
            end
         endcase
      end else if (accept) begin
         changed_in     = 1'b0;
         last_toggle_in = ref_time;
         case (mode_ff) inside
            lbb_pkg::MODE_OFF, lbb_pkg::MODE_ON: begin
               ctrl.wrote    = changed_ff;
               ctrl.pin_high = changed_ff &
                               ((mode_ff == lbb_pkg::MODE_ON) ^ active_low_ff);
            end
            lbb_pkg::MODE_SLOW, lbb_pkg::MODE_FAST: begin
               if (elapsed >= ((mode_ff == lbb_pkg::MODE_SLOW) ? SLOW_HALF : FAST_HALF)) begin
                  last_toggle_in = now_ms;
                  phase_in       = ~phase_ff;
                  ctrl.wrote     = 1'b1;
                  ctrl.pin_high  = ~phase_ff ^ active_low_ff;
               end
            end
            lbb_pkg::MODE_BREATHE: begin
               ctrl.wrote  = 1'b1;
               ctrl.is_pwm = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= lbb_pkg::MODE_OFF;
         active_low_ff  <= 1'b0;
         last_toggle_ff <= '0;
         phase_ff       <= 1'b0;
         changed_ff     <= 1'b0;
      end else begin
         mode_ff        <= mode_in;
         active_low_ff  <= active_low_in;
         last_toggle_ff <= last_toggle_in;
         phase_ff       <= phase_in;
         changed_ff     <= changed_in;
      end
   end

endmodule

// ===== hw/rtl/lbb_breathe.sv =====
// Breathe duty datapath: remainder by the period, folding, table read, polarity.
// Depends on lbb_pkg; the pipeline enables come from the top level.
`timescale 1ns / 1ps

module lbb_breathe (
   input  logic                          clock,
   input  lbb_pkg::stage_en_type         en,
   input  logic [lbb_pkg::TIME_W-1:0]    now_ms,
   input  lbb_pkg::ctrl_type             ctrl,
   output logic                          rsp_wrote,
   output logic                          rsp_is_pwm,
   output logic                          rsp_pin_high,
   output logic [lbb_pkg::DUTY_W-1:0]    rsp_pwm_duty
);

   localparam logic [lbb_pkg::TIME_W-1:0]   PERIOD_T = 32'(lbb_pkg::BREATHE_PERIOD_MS);
   localparam logic [lbb_pkg::PERIOD_W:0]   PERIOD_X =
      (lbb_pkg::PERIOD_W + 1)'(lbb_pkg::BREATHE_PERIOD_MS);
   localparam logic [lbb_pkg::DUTY_W-1:0]   DUTY_MAX = lbb_pkg::DUTY_W'(lbb_pkg::PWM_MAX);

   logic [lbb_pkg::TIME_W-1:0]  s1_now_ff;
   lbb_pkg::ctrl_type           s1_ctrl_ff;
   logic [lbb_pkg::TIME_W-1:0]  s2_now_ff;
   logic [lbb_pkg::QUOT_W-1:0]  s2_quot_ff, s2_quot_in;
   lbb_pkg::ctrl_type           s2_ctrl_ff;
   logic [lbb_pkg::PHASE_W-1:0] s3_phase_ff, s3_phase_in;
   lbb_pkg::ctrl_type           s3_ctrl_ff;
   logic [lbb_pkg::DUTY_W-1:0]  duty_ff, duty_in;
   lbb_pkg::ctrl_type           s4_ctrl_ff;

   logic [lbb_pkg::PROD_W-1:0]   recip_prod;
   logic [lbb_pkg::TIME_W-1:0]   quot_scaled;
   logic [lbb_pkg::TIME_W-1:0]   rem_raw;
   logic [lbb_pkg::TIME_W-1:0]   rem_fix;
   logic [lbb_pkg::PERIOD_W:0]   rem_k;
   logic [lbb_pkg::PERIOD_W:0]   folded;
   logic [lbb_pkg::DUTY_W-1:0]   table_duty;

   // The estimate from the truncated reciprocal is low by at most one.
   assign recip_prod = lbb_pkg::PROD_W'(s1_now_ff) * lbb_pkg::PROD_W'(lbb_pkg::BREATHE_RECIP);
   assign s2_quot_in = recip_prod[lbb_pkg::PROD_W-1:lbb_pkg::RECIP_SHIFT];

   assign quot_scaled = lbb_pkg::TIME_W'(s2_quot_ff) * PERIOD_T;
   assign rem_raw     = s2_now_ff - quot_scaled;
   assign rem_fix     = (rem_raw >= PERIOD_T) ? (rem_raw - PERIOD_T) : rem_raw;
   assign rem_k       = rem_fix[lbb_pkg::PERIOD_W:0];
   assign folded      = ({rem_k[lbb_pkg::PERIOD_W-1:0], 1'b0} > PERIOD_X) ?
                        (PERIOD_X - rem_k) : rem_k;
   assign s3_phase_in = folded[lbb_pkg::PHASE_W-1:0];

   assign table_duty = lbb_pkg::DUTY_TABLE[s3_phase_ff];
   always_comb begin
      if (!s3_ctrl_ff.is_pwm) begin
         duty_in = '0;
      end else if (s3_ctrl_ff.active_low) begin
         duty_in = DUTY_MAX - table_duty;
      end else begin
         duty_in = table_duty;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         s1_now_ff  <= now_ms;
         s1_ctrl_ff <= ctrl;
      end
      if (en.s2) begin
         s2_now_ff  <= s1_now_ff;
         s2_quot_ff <= s2_quot_in;
         s2_ctrl_ff <= s1_ctrl_ff;
      end
      if (en.s3) begin
         s3_phase_ff <= s3_phase_in;
         s3_ctrl_ff  <= s2_ctrl_ff;
      end
      if (en.s4) begin
         duty_ff    <= duty_in;
         s4_ctrl_ff <= s3_ctrl_ff;
      end
   end

   assign rsp_wrote    = s4_ctrl_ff.wrote;
   assign rsp_is_pwm   = s4_ctrl_ff.is_pwm;
   assign rsp_pin_high = s4_ctrl_ff.pin_high;
   assign rsp_pwm_duty = duty_ff;

endmodule

// ===== hw/rtl/led_blink_breathe_controller_top.sv =====
// Top level of the LED blink/breathe controller: handshakes, pipeline occupancy, assertions.
// Depends on lbb_pkg, lbb_ctrl and lbb_breathe.
`timescale 1ns / 1ps

// Channel   Ports                                    Handshake
// request   req_valid, req_stall, req_now_ms          valid high and stall low at the edge
// response  rsp_valid, rsp_stall, rsp_wrote,          valid high and stall low at the edge
//           rsp_is_pwm, rsp_pin_high, rsp_pwm_duty
// csr       csr_we, csr_index, csr_wdata              write enable high at the edge
//
// One request can be taken every cycle while the pipeline does not stall; its response is valid once
// it has passed through the registered stages s1 to s4, and it is taken while rsp_stall is low.
// The pipeline depth is set by the duty datapath: reciprocal multiply, remainder fold, table read.
// Blink and mode state are updated as the request is taken, so requests never wait on each other.
// Reset clears the registers, the blink state and the pipeline; the duty table is a constant.
// A stalled response holds its stage; bubbles close up, so requests stall only when all four
// stages are full.

module led_blink_breathe_controller_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [lbb_pkg::TIME_W-1:0]    req_now_ms,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_wrote,
   output logic                          rsp_is_pwm,
   output logic                          rsp_pin_high,
   output logic [lbb_pkg::DUTY_W-1:0]    rsp_pwm_duty,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [lbb_pkg::MODE_W-1:0]    csr_wdata
);

   logic                  v1_ff, v2_ff, v3_ff, v4_ff;
   lbb_pkg::stage_en_type en;
   lbb_pkg::ctrl_type     ctrl;
   logic                  accept;

   // A stage loads when it is empty or its contents move on in the same cycle.
   assign en.s4 = !v4_ff || !rsp_stall;
   assign en.s3 = !v3_ff || en.s4;
   assign en.s2 = !v2_ff || en.s3;
   assign en.s1 = !v1_ff || en.s2;

   assign req_stall = !en.s1;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en.s1) begin
            v1_ff <= accept;
         end
         if (en.s2) begin
            v2_ff <= v1_ff;
         end
         if (en.s3) begin
            v3_ff <= v2_ff;
         end
         if (en.s4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   lbb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .now_ms    (req_now_ms),
      .ctrl      (ctrl)
   );

   lbb_breathe u_breathe (
      .clock        (clock),
      .en           (en),
      .now_ms       (req_now_ms),
      .ctrl         (ctrl),
      .rsp_wrote    (rsp_wrote),
      .rsp_is_pwm   (rsp_is_pwm),
      .rsp_pin_high (rsp_pin_high),
      .rsp_pwm_duty (rsp_pwm_duty)
   );

   // Requests are only held off when the first stage is occupied.
   a_stall_needs_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> v1_ff)
      else $error("request stalled with an empty first stage");

   // With no response waiting, the pipeline must be able to take a request.
   a_empty_out_moves: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled although the response register is empty");

   // A PWM response is always a write.
   a_pwm_is_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_pwm) |-> rsp_wrote)
      else $error("PWM response without a write");

   // Digital responses carry no duty, and PWM responses no digital level.
   a_field_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_is_pwm && !rsp_pin_high) || (!rsp_is_pwm && rsp_pwm_duty == '0)))
      else $error("response mixes digital and PWM fields");

   // A request taken while the pipeline is full of stalled work cannot happen.
   a_no_take_when_full: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && v2_ff && v3_ff && v4_ff && rsp_stall) |-> !accept)
      else $error("request taken into a full stalled pipeline");

endmodule

// ===== tb/led_blink_breathe_controller_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the LED blink/breathe controller top level.
// Depends on lbb_pkg for widths, mode and register codes, and on led_blink_breathe_controller_top.

module led_blink_breathe_controller_top_test;

   localparam int TIME_W = lbb_pkg::TIME_W;
   localparam int DUTY_W = lbb_pkg::DUTY_W;
   localparam int MODE_W = lbb_pkg::MODE_W;

   localparam int CLOCK_HALF_NS = 4;
   localparam int RESET_CYCLES  = 11;
   localparam int MAX_IDLE      = 11;
   // Time left for the pipeline to settle after the last response is in.
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 200;
   localparam int RANDOM_TICKS  = 1400;
   // A run that goes past this limit is ended as a failure.
   localparam int CYCLE_LIMIT   = 400000;

   // Mode codes that the block does not define; ticks in these modes write nothing.
   localparam logic [MODE_W-1:0] MODE_RESERVED_FIRST = 3'd5;
   localparam logic [MODE_W-1:0] MODE_RESERVED_LAST  = 3'd7;

   localparam longint unsigned Q30_ONE = 64'd1 << 30;
   localparam longint unsigned Q30_PI  = 64'd3373259426;

   // One response as the block presents it.
   typedef struct packed {
      logic              wrote;
      logic              is_pwm;
      logic              pin_high;
      logic [DUTY_W-1:0] pwm_duty;
   } led_write_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [TIME_W-1:0]   req_now_ms;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_wrote;
   logic                rsp_is_pwm;
   logic                rsp_pin_high;
   logic [DUTY_W-1:0]   rsp_pwm_duty;
   logic                csr_we;
   logic                csr_index;
   logic [MODE_W-1:0]   csr_wdata;

   // Predicted controller state, starting from the reset values.
   logic [MODE_W-1:0]   mode_q        = lbb_pkg::MODE_OFF;
   logic                active_low_q  = 1'b0;
   logic [TIME_W-1:0]   toggle_ref_ms = '0;
   logic                blink_phase_q = 1'b0;
   logic                mode_pending  = 1'b0;

   led_write_type       expected_writes[$];
   led_write_type       got_write;
   led_write_type       want_write;

   // Idling switch shared by both sides, and the long hold-off of the response side.
   logic                idle_on  = 1'b1;
   logic                hold_rsp = 1'b0;

   int                  error_count  = 0;
   int                  ticks_sent   = 0;
   int                  results_seen = 0;
   int                  csr_writes   = 0;
   int                  random_phases = 0;
   int                  cycle_count  = 0;
   int                  rsp_wait     = 0;

   led_blink_breathe_controller_top DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_now_ms   (req_now_ms),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_wrote    (rsp_wrote),
      .rsp_is_pwm   (rsp_is_pwm),
      .rsp_pin_high (rsp_pin_high),
      .rsp_pwm_duty (rsp_pwm_duty),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF_NS clock = ~clock;
   end

   // A run that hangs, for instance on a response that never comes, ends here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d responses outstanding.",
                  cycle_count, expected_writes.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // Raised-cosine duty for one millisecond time: the phase within the period is folded onto
   // the first half, sin is taken by a Taylor series in Q30 up to the fifteenth power, then
   // squared and scaled to the PWM range.
   function automatic logic [DUTY_W-1:0] raised_cosine_duty(input logic [TIME_W-1:0] now_ms);
      longint unsigned period;
      longint unsigned k;
      longint unsigned j;
      longint unsigned x;
      longint unsigned term;
      longint unsigned s;
      longint unsigned q;
      longint unsigned d;
      longint          acc;
      period = longint'(lbb_pkg::BREATHE_PERIOD_MS);
      k = longint'(now_ms) % period;
      j = (2 * k > period) ? (period - k) : k;
      if (2 * j == period) begin
         s = Q30_ONE;
      end else begin
         x    = (Q30_PI * j) / period;
         term = x;
         acc  = longint'(x);
         for (int n = 1; n <= 7; n++) begin
            term = (((term * x) >> 30) * x) >> 30;
            term = term / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
               acc = acc - longint'(term);
            end else begin
               acc = acc + longint'(term);
            end
         end
         if (acc < 0) begin
            acc = 0;
         end
         s = longint'(acc);
         if (s > Q30_ONE) begin
            s = Q30_ONE;
         end
      end
      q = (s * s) >> 30;
      d = (longint'(lbb_pkg::PWM_MAX) * q) >> 30;
      if (d > longint'(lbb_pkg::PWM_MAX)) begin
         d = longint'(lbb_pkg::PWM_MAX);
      end
      return d[DUTY_W-1:0];
   endfunction

   // Advances the predicted state by one accepted tick and queues the response it must cause.
   task automatic predict_tick(input logic [TIME_W-1:0] now_ms);
      led_write_type     w;
      logic              fresh;
      logic [TIME_W-1:0] half;
      logic [DUTY_W-1:0] d;
      w     = '0;
      fresh = 1'b0;
      half  = '0;
      // The first tick after a mode change takes its own time as the toggle reference.
      if (mode_pending) begin
         toggle_ref_ms = now_ms;
         mode_pending  = 1'b0;
         fresh         = 1'b1;
      end
      case (mode_q)
         lbb_pkg::MODE_SLOW: half = TIME_W'(lbb_pkg::SLOW_HALF_PERIOD_MS);
         lbb_pkg::MODE_FAST: half = TIME_W'(lbb_pkg::FAST_HALF_PERIOD_MS);
         default:            half = '0;
      endcase
      if (mode_q == lbb_pkg::MODE_OFF || mode_q == lbb_pkg::MODE_ON) begin
         if (fresh) begin
            w.wrote    = 1'b1;
            w.pin_high = (mode_q == lbb_pkg::MODE_ON) ? ~active_low_q : active_low_q;
         end
      end else if (half != '0) begin
         if (TIME_W'(now_ms - toggle_ref_ms) >= half) begin
            toggle_ref_ms = now_ms;
            blink_phase_q = ~blink_phase_q;
            w.wrote       = 1'b1;
            w.pin_high    = blink_phase_q ^ active_low_q;
         end
      end else if (mode_q == lbb_pkg::MODE_BREATHE) begin
         d          = raised_cosine_duty(now_ms);
         w.wrote    = 1'b1;
         w.is_pwm   = 1'b1;
         w.pwm_duty = active_low_q ? DUTY_W'(lbb_pkg::PWM_MAX - int'(d)) : d;
      end
      expected_writes.push_back(w);
   endtask

   // Offers one tick, after a random gap while idling is on, and returns at the edge where it is taken.
   task automatic send_tick(input logic [TIME_W-1:0] now_ms);
      int gap;
      gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_now_ms <= now_ms;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_tick(now_ms);
      ticks_sent++;
   endtask

   // Stops offering requests and waits until every response is in and the pipeline is quiet.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_writes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register writes happen only with the block idle, so the prediction stays in step.
   task automatic write_csr(input logic reg_index, input logic [MODE_W-1:0] wdata);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= reg_index;
      csr_wdata <= wdata;
      @(posedge clock);
      csr_we <= 1'b0;
      csr_writes++;
      if (reg_index == lbb_pkg::CSR_LED_MODE) begin
         // Rewriting the current mode leaves the blink state alone.
         if (wdata != mode_q) begin
            mode_q        = wdata;
            blink_phase_q = 1'b0;
            mode_pending  = 1'b1;
         end
      end else begin
         active_low_q = wdata[0];
      end
   endtask

   // The response side: checks each response taken, then draws its own stall before the next.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got_write = '{rsp_wrote, rsp_is_pwm, rsp_pin_high, rsp_pwm_duty};
         results_seen++;
         if (expected_writes.size() == 0) begin
            $display("%0t ns: response with none expected: wrote=%0b pwm=%0b pin=%0b duty=%0d",
                     $time, got_write.wrote, got_write.is_pwm, got_write.pin_high,
                     got_write.pwm_duty);
            error_count++;
         end else begin
            want_write = expected_writes.pop_front();
            if (got_write !== want_write) begin
               $display({"%0t ns: mismatch: expected wrote=%0b pwm=%0b pin=%0b duty=%0d,",
                         " actual wrote=%0b pwm=%0b pin=%0b duty=%0d"},
                        $time, want_write.wrote, want_write.is_pwm, want_write.pin_high,
                        want_write.pwm_duty, got_write.wrote, got_write.is_pwm,
                        got_write.pin_high, got_write.pwm_duty);
               error_count++;
            end
         end
         rsp_wait = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      end else if (rsp_wait > 0) begin
         rsp_wait--;
      end
      rsp_stall <= hold_rsp || (rsp_wait > 0);
   end

   // Straight out of reset the mode is off with no change pending, so nothing is written.
   task automatic test_reset_state();
      send_tick(32'h0000_0000);
      send_tick(32'hFFFF_FFFF);
   endtask

   // On and off write their level once; a repeated mode or a new polarity writes nothing.
   task automatic test_static_levels();
      write_csr(lbb_pkg::CSR_ACTIVE_LOW, 3'b000);
      write_csr(lbb_pkg::CSR_LED_MODE, lbb_pkg::MODE_ON);
      send_tick(32'h0000_0001);
      send_tick(32'h0000_0002);
      write_csr(lbb_pkg::CSR_LED_MODE, lbb_pkg::MODE_ON);
      send_tick(32'h0000_0003);
      // Only bit 0 of the polarity register counts.
      write_csr(lbb_pkg::CSR_ACTIVE_LOW, 3'b111);
      send_tick(32'h0000_0004);
      write_csr(lbb_pkg::CSR_LED_MODE, lbb_pkg::MODE_OFF);
      send_tick(32'h0000_0005);
   endtask

   // Blink toggles at exactly the half period, also across the wrap of the time counter,
   // and a time that runs backwards looks like a huge elapsed time.
   task automatic test_blink();
      write_csr(lbb_pkg::CSR_LED_MODE, lbb_pkg::MODE_SLOW);
      send_tick(32'hFFFF_FF00);
      send_tick(32'hFFFF_FF00 + 32'(lbb_pkg::SLOW_HALF_PERIOD_MS - 1));
      send_tick(32'hFFFF_FF00 + 32'(lbb_pkg::SLOW_HALF_PERIOD_MS));
      write_csr(lbb_pkg::CSR_ACTIVE_LOW, 3'b000);
      write_csr(lbb_pkg::CSR_LED_MODE, lbb_pkg::MODE_FAST);
      send_tick(32'h0000_1000);
      send_tick(32'h0000_1000 + 32'(lbb_pkg::FAST_HALF_PERIOD_MS));
      send_tick(32'h0000_0FFF);
   endtask

   // Breathe at the ends and the middle of its period, in both polarities.
   task automatic test_breathe();
      write_csr(lbb_pkg::CSR_LED_MODE, lbb_pkg::MODE_BREATHE);
      send_tick(32'd0);
      send_tick(32'(lbb_pkg::BREATHE_PERIOD_MS / 2 - 1));
      send_tick(32'(lbb_pkg::BREATHE_PERIOD_MS / 2));
      send_tick(32'(lbb_pkg::BREATHE_PERIOD_MS / 2 + 1));
      send_tick(32'(lbb_pkg::BREATHE_PERIOD_MS - 1));
      send_tick(32'(lbb_pkg::BREATHE_PERIOD_MS));
      send_tick(32'hFFFF_FFFF);
      write_csr(lbb_pkg::CSR_ACTIVE_LOW, 3'b001);
      send_tick(32'(lbb_pkg::BREATHE_PERIOD_MS / 2));
      send_tick(32'd0);
   endtask

   // Undefined mode codes write nothing, even on the first tick after the change.
   task automatic test_reserved_modes();
      for (int m = MODE_RESERVED_FIRST; m <= MODE_RESERVED_LAST; m++) begin
         write_csr(lbb_pkg::CSR_LED_MODE, MODE_W'(m));
         send_tick($urandom);
      end
   endtask

   // The response side holds off for a long stretch while requests keep coming, so the
   // pipeline fills and stalls its input; then the sender pauses until all responses are in.
   task automatic test_backpressure();
      idle_on <= 1'b0;
      write_csr(lbb_pkg::CSR_LED_MODE, lbb_pkg::MODE_BREATHE);
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp <= 1'b0;
         end
      join_none
      for (int i = 0; i < 40; i++) begin
         send_tick($urandom);
      end
      idle_on <= 1'b1;
      wait_idle();
      for (int i = 0; i < 20; i++) begin
         send_tick($urandom);
      end
   endtask

   // Random phases: a mode and polarity, then a run of mostly advancing time with steps that
   // often hit the half periods exactly, mixed with backward steps and arbitrary times.
   task automatic test_random_phases();
      int                phase_len;
      int                r;
      int                sent;
      logic [TIME_W-1:0] now_ms;
      sent = 0;
      while (sent < RANDOM_TICKS) begin
         idle_on <= ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 9) < 8) begin
            write_csr(lbb_pkg::CSR_LED_MODE,
                      MODE_W'($urandom_range(lbb_pkg::MODE_OFF, lbb_pkg::MODE_BREATHE)));
         end else begin
            write_csr(lbb_pkg::CSR_LED_MODE,
                      MODE_W'($urandom_range(MODE_RESERVED_FIRST, MODE_RESERVED_LAST)));
         end
         if ($urandom_range(0, 1) == 1) begin
            write_csr(lbb_pkg::CSR_ACTIVE_LOW, MODE_W'($urandom_range(0, 7)));
         end
         now_ms = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3000)
                                              : $urandom;
         phase_len = $urandom_range(20, 120);
         for (int i = 0; i < phase_len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
               now_ms = $urandom;
            end else if (r < 20) begin
               case ($urandom_range(0, 3))
                  0:       now_ms = now_ms + 32'(lbb_pkg::FAST_HALF_PERIOD_MS);
                  1:       now_ms = now_ms + 32'(lbb_pkg::SLOW_HALF_PERIOD_MS);
                  2:       now_ms = now_ms + 32'(lbb_pkg::BREATHE_PERIOD_MS / 2);
                  default: now_ms = now_ms + 32'(lbb_pkg::BREATHE_PERIOD_MS);
               endcase
            end else if (r < 25) begin
               now_ms = now_ms - $urandom_range(1, 300);
            end else begin
               now_ms = now_ms + $urandom_range(0, 400);
            end
            send_tick(now_ms);
         end
         sent += phase_len;
         random_phases++;
      end
   endtask

   initial begin
      reset      <= 1'b1;
      req_valid  <= 1'b0;
      req_now_ms <= '0;
      csr_we     <= 1'b0;
      csr_index  <= lbb_pkg::CSR_LED_MODE;
      csr_wdata  <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_static_levels();
      test_blink();
      test_breathe();
      test_reserved_modes();
      test_backpressure();
      test_random_phases();

      // Wait for the last responses, then let the pipeline run empty.
      wait_idle();
      $display("Sent %0d requests over %0d random phases with %0d register writes;",
               ticks_sent, random_phases, csr_writes);
      $display("checked %0d responses, %0d mismatches.", results_seen, error_count);
      if (error_count == 0 && expected_writes.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
